// ----- rtl/core/sdr_pkg.sv -----
package sdr_pkg;

  localparam int WINDOW_DEPTH = 256;
  localparam int RING_AW      = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = RING_AW + 1;
  localparam int SUM_W        = 32 + RING_AW;
  localparam int PROD_W       = SUM_W + 32;
  localparam int DIV_W        = (PROD_W > 72) ? PROD_W : 72;
  localparam int DVS_W        = 48;
  localparam int DIV_CNT_W    = $clog2(DIV_W + 1);

  localparam int IN_W  = 144;
  localparam int OUT_W = 72;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_RETARGET_INTERVAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETARGET_SHARE_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_BUFFER          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECONDS_PER_SHARE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIFFICULTY       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFFICULTY       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE_THRESHOLD   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIME         = 3'd7;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_KEEP     = 3'd1;
  localparam logic [2:0] ACT_BAN      = 3'd2;
  localparam logic [2:0] ACT_SET      = 3'd3;
  localparam logic [2:0] ACT_DISCARD  = 3'd4;

  localparam logic [31:0] BAN_MIN_SHARES = 32'd200;
  localparam logic [DIV_W-1:0] DISCARD_PCT = DIV_W'(2000);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_TRIM_RD,
    S_TRIM_CK,
    S_SUM,
    S_MUL,
    S_MADD,
    S_DIV1S,
    S_DIV1W,
    S_VAR,
    S_DIV2S,
    S_DIV2W,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

// ----- rtl/core/sdr_div.sv -----
module sdr_div (
  input  logic                     clk,
  input  logic                     rst,
  input  sdr_pkg::div_req_t        req,
  output logic                     done,
  output logic [sdr_pkg::DIV_W-1:0] quot,
  output logic [sdr_pkg::DVS_W-1:0] rem
);

  logic                           busy;
  logic [sdr_pkg::DIV_CNT_W-1:0]  cnt;
  logic [sdr_pkg::DIV_W-1:0]      q;
  logic [sdr_pkg::DVS_W-1:0]      r;
  logic [sdr_pkg::DVS_W-1:0]      d;
  logic [sdr_pkg::DVS_W:0]        trial;
  logic [sdr_pkg::DVS_W:0]        diffv;
  logic                           fits;

  always_comb begin
    trial = {r, q[sdr_pkg::DIV_W-1]};
    diffv = trial - {1'b0, d};
    fits  = trial >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= sdr_pkg::DIV_CNT_W'(sdr_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == sdr_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q <= req.dividend;
      r <= '0;
      d <= req.divisor;
    end else if (busy) begin
      r <= fits ? diffv[sdr_pkg::DVS_W-1:0] : trial[sdr_pkg::DVS_W-1:0];
      q <= {q[sdr_pkg::DIV_W-2:0], fits};
    end
  end

  assign quot = q;
  assign rem  = r;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider restarted while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (done && d != '0) |-> (r < d))
    else $error("remainder not below divisor");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0 && cnt <= sdr_pkg::DIV_CNT_W'(sdr_pkg::DIV_W)))
    else $error("divider step count out of range");
`endif

endmodule

// ----- rtl/core/share_difficulty_retarget.sv -----
// channel  dir  handshake          payload (lowest bit up)
// s_       in   s_tvalid/s_tready  share_diff 32, now_seconds 32, bad_share_total 32,
//                                  current_difficulty 48
// m_       out  m_tvalid/m_tready  accept 1, action 3, new_difficulty 48,
//                                  variance_percent 16, 4 zero pad bits
// cfg_     in   cfg_we             cfg_index 3, cfg_data 48
// A share without retarget, or a banned one, goes from the check straight to the
// result; a retarget trims T shares and sums N window shares from the ring
// memory's single read port, then runs up to two passes of the shared 72-bit divider.
// Reset (rst, synchronous) empties the ring by clearing head and count; no sweep.
// One share at a time; a held result stalls the next share's result until taken.
module share_difficulty_retarget (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sdr_pkg::IN_W-1:0]        s_tdata,   // share_diff, now_seconds,
                                                     // bad_share_total, current_difficulty
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sdr_pkg::OUT_W-1:0]       m_tdata,   // accept, action, new_difficulty,
                                                     // variance_percent
  input  logic                            cfg_we,
  input  logic [sdr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdr_pkg::CFG_W-1:0]       cfg_data
);

  logic [15:0] retarget_interval, retarget_share_count, time_buffer, variance_threshold;
  logic [31:0] seconds_per_share, connect_time;
  logic [47:0] min_difficulty, max_difficulty;

  sdr_pkg::state_t state, state_next;

  logic [31:0] now_r, bad_r, share_total, last_time, last_shares;
  logic [47:0] cur_r;
  logic [sdr_pkg::RING_AW-1:0] ring_head;
  logic [sdr_pkg::CNT_W-1:0]   ring_count, idx;
  logic                        pend;
  logic [sdr_pkg::SUM_W-1:0]   sum;
  logic [63:0]                 p_lo;
  logic [sdr_pkg::SUM_W-1:0]   p_hi;
  logic [sdr_pkg::DIV_W-1:0]   prod, xdiv;
  logic [15:0]                 interval;
  logic [47:0]                 nd;

  logic        res_accept;
  logic [2:0]  res_action;
  logic [47:0] res_nd;
  logic [15:0] res_var;

  logic [63:0] ring_mem [sdr_pkg::WINDOW_DEPTH];
  logic [63:0] rd_data;
  logic        rd_en, wr_en, load_out;
  logic [sdr_pkg::RING_AW-1:0] rd_addr, wr_addr;

  sdr_pkg::div_req_t div_req;
  logic                      div_done;
  logic [sdr_pkg::DIV_W-1:0] div_quot;
  logic [sdr_pkg::DVS_W-1:0] div_rem;

  logic [sdr_pkg::RING_AW-1:0] head_adj;
  logic [sdr_pkg::CNT_W-1:0]   count_adj;
  logic [31:0] since_t, since_s, age, elapsed;
  logic        retarget, ban, trim_drop;
  logic [35:0] bad10, tot9;
  logic [48:0] nd_sat, nd_lo;
  logic [47:0] absd;
  logic        accept_in;

  sdr_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      retarget_interval    <= 16'd90;
      retarget_share_count <= 16'd20;
      time_buffer          <= 16'd300;
      seconds_per_share    <= 32'd983040;
      min_difficulty       <= 48'd65536;
      max_difficulty       <= '1;
      variance_threshold   <= 16'd20;
      connect_time         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sdr_pkg::CFG_RETARGET_INTERVAL:    retarget_interval    <= cfg_data[15:0];
        sdr_pkg::CFG_RETARGET_SHARE_COUNT: retarget_share_count <= cfg_data[15:0];
        sdr_pkg::CFG_TIME_BUFFER:          time_buffer          <= cfg_data[15:0];
        sdr_pkg::CFG_SECONDS_PER_SHARE:    seconds_per_share    <= cfg_data[31:0];
        sdr_pkg::CFG_MIN_DIFFICULTY:       min_difficulty       <= cfg_data[47:0];
        sdr_pkg::CFG_MAX_DIFFICULTY:       max_difficulty       <= cfg_data[47:0];
        sdr_pkg::CFG_VARIANCE_THRESHOLD:   variance_threshold   <= cfg_data[15:0];
        sdr_pkg::CFG_CONNECT_TIME:         connect_time         <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    accept_in = s_tvalid && s_tready;
    if (ring_count == sdr_pkg::CNT_W'(sdr_pkg::WINDOW_DEPTH)) begin
      head_adj  = ring_head + 1'b1;
      count_adj = sdr_pkg::CNT_W'(sdr_pkg::WINDOW_DEPTH - 1);
    end else begin
      head_adj  = ring_head;
      count_adj = ring_count;
    end
    since_t   = now_r - last_time;
    since_s   = share_total - last_shares;
    retarget  = !(since_t < {16'd0, retarget_interval} &&
                  since_s < {16'd0, retarget_share_count});
    bad10     = {4'd0, bad_r} * 36'd10;
    tot9      = {4'd0, share_total} * 36'd9;
    ban       = (share_total > sdr_pkg::BAN_MIN_SHARES) && (bad10 > tot9);
    age       = now_r - rd_data[63:32];
    trim_drop = age >= {16'd0, time_buffer};
    elapsed   = now_r - connect_time;
    nd_sat    = (div_quot[sdr_pkg::DIV_W-1:48] != '0) ? {1'b1, 48'd0}
                                                      : {1'b0, div_quot[47:0]};
    nd_lo     = (nd_sat < {1'b0, min_difficulty}) ? {1'b0, min_difficulty} : nd_sat;
    absd      = (nd >= cur_r) ? nd - cur_r : cur_r - nd;
  end

  always_comb begin
    state_next = state;
    case (state)
      sdr_pkg::S_IDLE:    if (s_tvalid) state_next = sdr_pkg::S_CHECK;
      sdr_pkg::S_CHECK:   state_next = (!retarget || ban) ? sdr_pkg::S_EMIT : sdr_pkg::S_TRIM_RD;
      sdr_pkg::S_TRIM_RD: state_next = (ring_count == '0) ? sdr_pkg::S_SUM : sdr_pkg::S_TRIM_CK;
      sdr_pkg::S_TRIM_CK: state_next = trim_drop ? sdr_pkg::S_TRIM_RD : sdr_pkg::S_SUM;
      sdr_pkg::S_SUM:     if (idx == ring_count && !pend) state_next = sdr_pkg::S_MUL;
      sdr_pkg::S_MUL:     state_next = sdr_pkg::S_MADD;
      sdr_pkg::S_MADD:    state_next = sdr_pkg::S_DIV1S;
      sdr_pkg::S_DIV1S:   state_next = sdr_pkg::S_DIV1W;
      sdr_pkg::S_DIV1W:   if (div_done) state_next = sdr_pkg::S_VAR;
      sdr_pkg::S_VAR:     state_next = (cur_r == '0) ? sdr_pkg::S_EMIT : sdr_pkg::S_DIV2S;
      sdr_pkg::S_DIV2S:   state_next = sdr_pkg::S_DIV2W;
      sdr_pkg::S_DIV2W:   if (div_done) state_next = sdr_pkg::S_EMIT;
      sdr_pkg::S_EMIT:    if (!m_tvalid || m_tready) state_next = sdr_pkg::S_IDLE;
      default:            state_next = sdr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready         = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = ring_head;
    wr_en            = 1'b0;
    wr_addr          = head_adj + count_adj[sdr_pkg::RING_AW-1:0];
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod;
    div_req.divisor  = {32'd0, interval};
    case (state)
      sdr_pkg::S_IDLE: begin
        s_tready = 1'b1;
        wr_en    = s_tvalid;
      end
      sdr_pkg::S_TRIM_RD: rd_en = (ring_count != '0);
      sdr_pkg::S_SUM: begin
        rd_en   = idx < ring_count;
        rd_addr = ring_head + idx[sdr_pkg::RING_AW-1:0];
      end
      sdr_pkg::S_DIV1S: div_req.start = 1'b1;
      sdr_pkg::S_DIV2S: begin
        div_req.start    = 1'b1;
        div_req.dividend = xdiv;
        div_req.divisor  = cur_r;
      end
      sdr_pkg::S_EMIT: load_out = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[wr_addr] <= {s_tdata[63:32], s_tdata[31:0]};
    if (rd_en) rd_data <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sdr_pkg::S_IDLE;
      share_total <= '0;
      last_time   <= '0;
      last_shares <= '0;
      ring_head   <= '0;
      ring_count  <= '0;
      idx         <= '0;
      pend        <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        sdr_pkg::S_IDLE: if (accept_in) begin
          share_total <= share_total + 1'b1;
          ring_head   <= head_adj;
          ring_count  <= count_adj + 1'b1;
        end
        sdr_pkg::S_CHECK: begin
          idx  <= '0;
          pend <= 1'b0;
          if (retarget) begin
            last_time   <= now_r;
            last_shares <= share_total;
          end
        end
        sdr_pkg::S_TRIM_CK: if (trim_drop) begin
          ring_head  <= ring_head + 1'b1;
          ring_count <= ring_count - 1'b1;
        end
        sdr_pkg::S_SUM: begin
          if (rd_en) idx <= idx + 1'b1;
          pend <= rd_en;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) m_tdata <= {4'd0, res_var, res_nd, res_action, res_accept};
    case (state)
      sdr_pkg::S_IDLE: if (accept_in) begin
        now_r        <= s_tdata[63:32];
        bad_r        <= s_tdata[95:64];
        cur_r        <= s_tdata[143:96];
      end
      sdr_pkg::S_CHECK: begin
        sum        <= '0;
        res_nd     <= '0;
        res_var    <= '0;
        res_accept <= retarget ? !ban : 1'b1;
        res_action <= !retarget ? sdr_pkg::ACT_NONE : sdr_pkg::ACT_BAN;
      end
      sdr_pkg::S_SUM: if (pend) sum <= sum + sdr_pkg::SUM_W'(rd_data[31:0]);
      sdr_pkg::S_MUL: begin
        p_lo <= 64'(sum[31:0]) * 64'(seconds_per_share);
        p_hi <= sdr_pkg::SUM_W'(sum[sdr_pkg::SUM_W-1:32] * seconds_per_share);
        if (now_r < connect_time || elapsed >= {16'd0, time_buffer}) begin
          interval <= (time_buffer == '0) ? 16'd1 : time_buffer;
        end else begin
          interval <= (elapsed[15:0] == '0) ? 16'd1 : elapsed[15:0];
        end
      end
      sdr_pkg::S_MADD: prod <= sdr_pkg::DIV_W'(p_lo) + (sdr_pkg::DIV_W'(p_hi) << 32);
      sdr_pkg::S_DIV1W: if (div_done) begin
        nd <= (nd_lo > {1'b0, max_difficulty}) ? max_difficulty : nd_lo[47:0];
      end
      sdr_pkg::S_VAR: begin
        res_nd     <= nd;
        res_var    <= 16'hFFFF;
        res_accept <= 1'b0;
        res_action <= sdr_pkg::ACT_DISCARD;
        xdiv       <= sdr_pkg::DIV_W'({7'd0, absd} * 55'd100);
      end
      sdr_pkg::S_DIV2W: if (div_done) begin
        res_var <= (div_quot[sdr_pkg::DIV_W-1:16] != '0) ? 16'hFFFF : div_quot[15:0];
        if (div_quot < sdr_pkg::DIV_W'(variance_threshold)) begin
          res_accept <= 1'b1;
          res_action <= sdr_pkg::ACT_KEEP;
        end else if (div_quot > sdr_pkg::DISCARD_PCT ||
                     (div_quot == sdr_pkg::DISCARD_PCT && div_rem != '0)) begin
          res_accept <= 1'b0;
          res_action <= sdr_pkg::ACT_DISCARD;
        end else begin
          res_accept <= 1'b1;
          res_action <= sdr_pkg::ACT_SET;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= sdr_pkg::CNT_W'(sdr_pkg::WINDOW_DEPTH))
    else $error("ring count above depth");
  a_store_nonempty: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (ring_count != '0 && state == sdr_pkg::S_CHECK))
    else $error("share not stored");
  a_ban_stops: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3:1] == sdr_pkg::ACT_BAN) |-> (m_tdata[0] == 1'b0))
    else $error("ban result keeps accepting");
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3:1] == sdr_pkg::ACT_NONE) |-> (m_tdata[67:4] == '0))
    else $error("no-retarget result carries data");
`endif

endmodule
